>>> rtl/kte_pkg.sv
package kte_pkg;

  localparam int KEY_W       = 8;
  localparam int TIME_W      = 32;
  localparam int DELAY_W     = 16;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;
  localparam int NUM_KEYS_DEFAULT = 256;

  localparam logic [DELAY_W-1:0] INITIAL_DELAY_RESET   = 16'd500;
  localparam logic [DELAY_W-1:0] CONTINUED_DELAY_RESET = 16'd75;

  typedef enum logic [APB_ADDR_W-1:0] {
    REG_INITIAL_DELAY   = 3'd0,
    REG_CONTINUED_DELAY = 3'd4
  } kte_reg_addr_t;

  // One word of per-key state as kept in the key memory.
  typedef struct packed {
    logic              level;
    logic              fast;
    logic [TIME_W-1:0] press_time;
  } kte_entry_t;

endpackage

>>> rtl/kte_if.sv
interface kte_in_if
  import kte_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [KEY_W-1:0]  key_code;
  logic              key_down;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, key_code, key_down, now_ms, input ready);
  modport sink (input valid, key_code, key_down, now_ms, output ready);
endinterface

interface kte_out_if
  import kte_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] event_key;
  logic             event_is_press;

  modport source (output valid, event_key, event_is_press, input ready);
  modport sink (input valid, event_key, event_is_press, output ready);
endinterface

>>> rtl/kte_ram.sv
module kte_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/key_edge_typematic_repeat_core.sv
// Keyboard typematic auto-repeat for a scanned key matrix.
// Input channel in_ch: one key sample per request (key code, pressed level,
// millisecond tick). Result channel out_ch: a press, repeat or release event
// (key code and a press flag); samples that cause no event produce nothing.
// Key codes at or above NUM_KEYS are dropped without a state change.
// The APB port sets the initial and continued repeat delays in milliseconds.
// Throughput is one request per cycle unless an event waits in the decision
// stage for the receiver. The key memory is read when a request is accepted;
// the edge and repeat decision then loads the output register for out_ch.
// The per-key state lives in a single memory with one read and one write
// port; the write of one sample is forwarded to the next so that the same
// key may be sampled on consecutive cycles.
// After reset the block clears the key memory, one key per cycle, from key
// 0 to NUM_KEYS-1; in_ch.ready stays low during that pass.
// When the receiver stalls, the event waits in the output register; samples
// that produce no event keep flowing, and the first one that does produce an
// event waits in the decision stage until the output register frees up.
module key_edge_typematic_repeat_core
  import kte_pkg::*;
#(
  parameter int NUM_KEYS = NUM_KEYS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  kte_in_if.sink                in_ch,
  kte_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int AW = $clog2(NUM_KEYS);

  logic [DELAY_W-1:0] init_delay_r;
  logic [DELAY_W-1:0] cont_delay_r;

  logic          clearing_r;
  logic [AW-1:0] clr_idx_r;

  logic              s1_valid_r;
  logic [AW-1:0]     s1_addr_r;
  logic [KEY_W-1:0]  s1_key_r;
  logic              s1_down_r;
  logic [TIME_W-1:0] s1_now_r;

  logic          fwd_valid_r;
  logic [AW-1:0] fwd_addr_r;
  kte_entry_t    fwd_data_r;

  logic             out_valid_r;
  logic [KEY_W-1:0] out_key_r;
  logic             out_press_r;

  logic              in_accept;
  logic              in_range;
  logic [AW-1:0]     in_addr;
  kte_entry_t        rd_entry;
  kte_entry_t        cur;
  kte_entry_t        upd;
  logic              new_press;
  logic              new_release;
  logic              fast_eff;
  logic              do_repeat;
  logic [DELAY_W-1:0] delay;
  logic [TIME_W-1:0] elapsed;
  logic              emit;
  logic              s1_advance;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  kte_entry_t        ram_wdata;
  logic              cfg_write;

  // ---------------- configuration ----------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_delay_r <= INITIAL_DELAY_RESET;
      cont_delay_r <= CONTINUED_DELAY_RESET;
    end else if (cfg_write) begin
      case (paddr)
        REG_INITIAL_DELAY:   init_delay_r <= pwdata[DELAY_W-1:0];
        REG_CONTINUED_DELAY: cont_delay_r <= pwdata[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      REG_INITIAL_DELAY:   prdata = APB_DATA_W'(init_delay_r);
      REG_CONTINUED_DELAY: prdata = APB_DATA_W'(cont_delay_r);
      default:             prdata = '0;
    endcase
  end

  // ---------------- memory clearing pass ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clearing_r) begin
      clr_idx_r <= clr_idx_r + AW'(1);
      if (clr_idx_r == AW'(NUM_KEYS - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // ---------------- input and read stage ----------------
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign in_range    = 32'(in_ch.key_code) < NUM_KEYS;
  assign in_addr     = AW'(in_ch.key_code);
  assign in_ch.ready = !clearing_r && (!s1_valid_r || s1_advance);

  kte_ram #(
    .WIDTH ($bits(kte_entry_t)),
    .DEPTH (NUM_KEYS)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_accept),
    .raddr (in_addr),
    .rdata (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= in_range;
    end else if (s1_advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_addr_r <= in_addr;
      s1_key_r  <= in_ch.key_code;
      s1_down_r <= in_ch.key_down;
      s1_now_r  <= in_ch.now_ms;
    end
  end

  // ---------------- decision stage ----------------
  // The memory read of this sample may have happened at the same edge as the write of
  // the sample before it, so the last write is forwarded when the keys match.
  assign cur = (fwd_valid_r && fwd_addr_r == s1_addr_r) ? fwd_data_r : rd_entry;

  always_comb begin
    new_press   = s1_down_r && !cur.level;
    new_release = !s1_down_r && cur.level;
    fast_eff    = cur.fast && !new_press;
    delay       = fast_eff ? cont_delay_r : init_delay_r;
    elapsed     = s1_now_r - cur.press_time;
    // A stored tick of zero means no usable press time, so no repeat.
    do_repeat   = !new_press && s1_down_r && (cur.press_time != '0) &&
                  (elapsed >= TIME_W'(delay));
    emit        = new_press || do_repeat || new_release;

    upd.level      = s1_down_r;
    upd.fast       = fast_eff || do_repeat;
    upd.press_time = (new_press || do_repeat) ? s1_now_r : cur.press_time;
  end

  assign s1_advance = s1_valid_r && (!emit || !out_valid_r || out_ch.ready);

  always_comb begin
    if (clearing_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx_r;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_advance;
      ram_waddr = s1_addr_r;
      ram_wdata = upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else if (s1_advance) begin
      fwd_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      fwd_addr_r <= s1_addr_r;
      fwd_data_r <= upd;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_advance && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && emit) begin
      out_key_r   <= s1_key_r;
      out_press_r <= new_press || do_repeat;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.event_key      = out_key_r;
  assign out_ch.event_is_press = out_press_r;

endmodule
